[rtl/cereg_status_parser_defines.svh]
// Assertion macros shared by the status parser RTL.
`ifndef CEREG_STATUS_PARSER_DEFINES_SVH
`define CEREG_STATUS_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define CEREG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define CEREG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CEREG_ASSERT(lbl, prop, msg)
`define CEREG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/cereg_pkg.sv]
// Types, constants and helper functions of the status parser.
package cereg_pkg;

  localparam int unsigned PrefixLen = 7;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned MaskWidth = 16;

  localparam logic [MaskWidth-1:0] RegMaskReset   = 16'd34;
  localparam logic [MaskWidth-1:0] UnregMaskReset = 16'd29;

  // Register select bit of paddr: register i lies at byte address 4*i.
  localparam logic RegSelRegistered   = 1'b0;
  localparam logic RegSelUnregistered = 1'b1;

  localparam logic [7:0] ChrPlus  = 8'h2B;
  localparam logic [7:0] ChrComma = 8'h2C;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;

  typedef enum logic [1:0] {
    CLS_REGISTERED   = 2'd0,
    CLS_UNREGISTERED = 2'd1,
    CLS_OTHER        = 2'd2,
    CLS_MALFORMED    = 2'd3
  } status_class_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_NUM1  = 3'd2,
    PH_GAP   = 3'd3,
    PH_LEAD2 = 3'd4,
    PH_NUM2  = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [1:0] status_class;
    logic [7:0] status_code;
  } out_t;

  // Characters of the "+CEREG:" prefix.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2B;
      3'd1:    c = 8'h43;
      3'd2:    c = 8'h45;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h45;
      3'd5:    c = 8'h47;
      3'd6:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChrZero) && (c <= ChrNine);
  endfunction

  // acc * 10 + digit, saturating at 255.
  function automatic logic [7:0] accumulate(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] sum;
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, c[3:0]};
    return (sum > 12'd255) ? 8'hFF : sum[7:0];
  endfunction

endpackage

[rtl/cereg_status_parser.sv]
// Top level of the +CEREG response parser: byte intake, parser state machine and result register.
//
// The parser takes one response byte per transaction and watches the byte stream
// for the "+CEREG:" prefix. After the prefix it skips spaces, CR and LF, reads a
// decimal number, skips spaces and, if a comma follows, reads a second number
// that becomes the status; otherwise the first number is the status. A number is
// only taken once a non-digit byte ends it, and each number saturates at 255. The
// status is classed through two writable code masks as registered, not
// registered or other (registered wins if a code is in both masks), and a missing
// number gives a malformed result with code zero. At most one result transaction
// follows each input transaction, and after a result the parser ignores bytes
// until a byte arrives with restart set, which clears the parser before that byte
// is looked at. Throughput is one byte per clock cycle while the result register
// is free or being taken: each accepted byte is stored in the input register, the
// state machine then handles it in a single pass and, where it ends a field,
// loads the result register, from which the result is offered. A full result
// register that is not being taken holds the input register, and this is what
// sets the input side's ready. The masks are written through the APB port at
// byte address 0 (registered mask) and 4 (not-registered mask); they reset to
// codes 1 and 5, and to codes 0, 2, 3 and 4 respectively.
module cereg_status_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cereg_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cereg_pkg::out_t                     out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cereg_pkg::AddrWidth-1:0]     paddr,
  input  logic [cereg_pkg::DataWidth-1:0]     pwdata,
  output logic [cereg_pkg::DataWidth-1:0]     prdata,
  output logic                                pready
);

`include "cereg_status_parser_defines.svh"

  // Configuration registers.
  logic [cereg_pkg::MaskWidth-1:0] reg_mask_r;
  logic [cereg_pkg::MaskWidth-1:0] unreg_mask_r;
  logic                            cfg_wr;

  // Input register.
  logic           stg_valid_r;
  cereg_pkg::in_t stg_data_r;
  logic           stg_fire;

  // Result register.
  logic            out_valid_r;
  cereg_pkg::out_t out_data_r;
  logic            out_valid_nxt;

  // Parser state.
  cereg_pkg::phase_t phase_r, phase_nxt, phase_cur;
  logic [2:0]        pfx_idx_r, pfx_idx_nxt, pfx_idx_cur;
  logic [7:0]        num1_r, num1_nxt, num1_cur;
  logic [7:0]        num2_r, num2_nxt;

  // Result of the current byte.
  logic                     emit;
  logic                     emit_malformed;
  logic [7:0]               emit_code;
  cereg_pkg::status_class_t emit_class;

  logic [7:0] c;
  logic       c_digit;
  logic       c_space;
  logic       c_comma;
  logic       c_blank;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes are taken in the access phase; the low address
  // bits below the register select are not decoded.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_mask_r   <= cereg_pkg::RegMaskReset;
      unreg_mask_r <= cereg_pkg::UnregMaskReset;
    end else if (cfg_wr) begin
      if (paddr[2] == cereg_pkg::RegSelRegistered) begin
        reg_mask_r <= pwdata[cereg_pkg::MaskWidth-1:0];
      end else begin
        unreg_mask_r <= pwdata[cereg_pkg::MaskWidth-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == cereg_pkg::RegSelUnregistered) begin
      prdata[cereg_pkg::MaskWidth-1:0] = unreg_mask_r;
    end else begin
      prdata[cereg_pkg::MaskWidth-1:0] = reg_mask_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes. The input register moves on whenever the result register can
  // take a value, whether or not this byte produces one.
  // ---------------------------------------------------------------------------
  assign stg_fire  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || stg_fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_data_r <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser. A restart clears the state before the byte is looked at.
  // ---------------------------------------------------------------------------
  assign c           = stg_data_r.rx_byte;
  assign c_digit     = cereg_pkg::is_digit(c);
  assign c_space     = (c == cereg_pkg::ChrSpace);
  assign c_comma     = (c == cereg_pkg::ChrComma);
  assign c_blank     = c_space || (c == cereg_pkg::ChrCr) || (c == cereg_pkg::ChrLf);
  assign phase_cur   = stg_data_r.restart ? cereg_pkg::PH_HUNT : phase_r;
  assign pfx_idx_cur = stg_data_r.restart ? 3'd0 : pfx_idx_r;
  assign num1_cur    = stg_data_r.restart ? 8'd0 : num1_r;

  // Next state.
  always_comb begin
    phase_nxt   = phase_cur;
    pfx_idx_nxt = pfx_idx_cur;
    num1_nxt    = num1_cur;
    num2_nxt    = stg_data_r.restart ? 8'd0 : num2_r;
    case (phase_cur)
      cereg_pkg::PH_HUNT: begin
        if ((32'(pfx_idx_cur) < cereg_pkg::PrefixLen) &&
            (c == cereg_pkg::prefix_char(pfx_idx_cur))) begin
          if (32'(pfx_idx_cur) == cereg_pkg::PrefixLen - 1) begin
            pfx_idx_nxt = 3'd0;
            phase_nxt   = cereg_pkg::PH_LEAD;
          end else begin
            pfx_idx_nxt = pfx_idx_cur + 3'd1;
          end
        end else begin
          // A broken prefix restarts the hunt, a '+' counting as its start.
          pfx_idx_nxt = (c == cereg_pkg::ChrPlus) ? 3'd1 : 3'd0;
        end
      end
      cereg_pkg::PH_LEAD: begin
        if (!c_blank) begin
          if (c_digit) begin
            num1_nxt  = cereg_pkg::accumulate(8'd0, c);
            phase_nxt = cereg_pkg::PH_NUM1;
          end else begin
            phase_nxt = cereg_pkg::PH_DONE;
          end
        end
      end
      cereg_pkg::PH_NUM1: begin
        if (c_digit) begin
          num1_nxt = cereg_pkg::accumulate(num1_cur, c);
        end else if (c_space) begin
          phase_nxt = cereg_pkg::PH_GAP;
        end else if (c_comma) begin
          phase_nxt = cereg_pkg::PH_LEAD2;
        end else begin
          phase_nxt = cereg_pkg::PH_DONE;
        end
      end
      cereg_pkg::PH_GAP: begin
        if (c_comma) begin
          phase_nxt = cereg_pkg::PH_LEAD2;
        end else if (!c_space) begin
          phase_nxt = cereg_pkg::PH_DONE;
        end
      end
      cereg_pkg::PH_LEAD2: begin
        if (c_digit) begin
          num2_nxt  = cereg_pkg::accumulate(8'd0, c);
          phase_nxt = cereg_pkg::PH_NUM2;
        end else if (!c_space) begin
          phase_nxt = cereg_pkg::PH_DONE;
        end
      end
      cereg_pkg::PH_NUM2: begin
        if (c_digit) begin
          num2_nxt = cereg_pkg::accumulate(num2_r, c);
        end else begin
          phase_nxt = cereg_pkg::PH_DONE;
        end
      end
      default: begin
        phase_nxt = cereg_pkg::PH_DONE;
      end
    endcase
  end

  // Outputs: which bytes end a field, and what they report.
  always_comb begin
    emit           = 1'b0;
    emit_malformed = 1'b0;
    emit_code      = num1_cur;
    case (phase_cur)
      cereg_pkg::PH_LEAD: begin
        emit           = !c_blank && !c_digit;
        emit_malformed = 1'b1;
      end
      cereg_pkg::PH_NUM1: begin
        emit = !c_digit && !c_space && !c_comma;
      end
      cereg_pkg::PH_GAP: begin
        emit = !c_space && !c_comma;
      end
      cereg_pkg::PH_LEAD2: begin
        emit           = !c_space && !c_digit;
        emit_malformed = 1'b1;
      end
      cereg_pkg::PH_NUM2: begin
        emit      = !c_digit;
        emit_code = num2_r;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Classification through the masks; registered takes priority.
  always_comb begin
    if (emit_malformed) begin
      emit_class = cereg_pkg::CLS_MALFORMED;
    end else if ((emit_code[7:4] == 4'd0) && reg_mask_r[emit_code[3:0]]) begin
      emit_class = cereg_pkg::CLS_REGISTERED;
    end else if ((emit_code[7:4] == 4'd0) && unreg_mask_r[emit_code[3:0]]) begin
      emit_class = cereg_pkg::CLS_UNREGISTERED;
    end else begin
      emit_class = cereg_pkg::CLS_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cereg_pkg::PH_HUNT;
      pfx_idx_r <= 3'd0;
      num1_r    <= 8'd0;
      num2_r    <= 8'd0;
    end else if (stg_fire) begin
      phase_r   <= phase_nxt;
      pfx_idx_r <= pfx_idx_nxt;
      num1_r    <= num1_nxt;
      num2_r    <= num2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (stg_fire && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_fire && emit) begin
      out_data_r.status_class <= emit_class;
      out_data_r.status_code  <= emit_malformed ? 8'd0 : emit_code;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `CEREG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !stg_valid_r, "reset left data valid")
  `CEREG_ASSERT(a_emit_done, stg_fire && emit |=> out_valid_r && (phase_r == cereg_pkg::PH_DONE), "result did not end the field")
  `CEREG_ASSERT(a_malformed_zero, out_valid_r && (out_data_r.status_class == cereg_pkg::CLS_MALFORMED) |-> out_data_r.status_code == 8'd0, "malformed result carries a code")
  `CEREG_ASSERT(a_class_small, out_valid_r && ((out_data_r.status_class == cereg_pkg::CLS_REGISTERED) || (out_data_r.status_class == cereg_pkg::CLS_UNREGISTERED)) |-> out_data_r.status_code < 8'd16, "masked class for a code above 15")
  `CEREG_ASSERT(a_done_silent, stg_fire && !stg_data_r.restart && (phase_r == cereg_pkg::PH_DONE) |-> !emit, "result after the field was done")

endmodule
